/* rtl/wrp_pkg.sv */
// types, codes and constants shared by the waypoint record parser
// no dependencies; imported by every rtl module of the parser
`default_nettype none

package wrp_pkg;

  // fixed part of a record: version, flags, id, lat, lon, expiry, lock, three lengths
  localparam int unsigned MIN_RECORD_BYTES = 1 + 2 + 4 + 4 + 4 + 4 + 4 + 2 + 2 + 2;
  localparam int unsigned SEEN_W           = $clog2(MIN_RECORD_BYTES + 1);
  localparam int unsigned HEADER_BYTES     = 22;
  localparam int unsigned HDR_W            = HEADER_BYTES * 8;
  localparam int unsigned IDX_W            = $clog2(HEADER_BYTES);
  localparam int unsigned CFG_W            = 16;
  localparam int unsigned CFG_IDX_W        = 2;
  localparam int unsigned QUEUE_DEPTH      = 4;

  localparam logic [7:0]  RST_EXPECTED_VERSION = 8'd1;
  localparam logic [15:0] RST_NAME_LIMIT       = 16'd32;
  localparam logic [15:0] RST_DESC_LIMIT       = 16'd256;
  localparam logic [15:0] RST_ICON_LIMIT       = 16'd32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EXPECTED_VERSION = 2'd0,
    CFG_NAME_LIMIT       = 2'd1,
    CFG_DESC_LIMIT       = 2'd2,
    CFG_ICON_LIMIT       = 2'd3
  } cfg_reg_e;

  typedef enum logic [3:0] {
    PH_VERSION  = 4'd0,
    PH_HEADER   = 4'd1,
    PH_NAME_LEN = 4'd2,
    PH_NAME_TXT = 4'd3,
    PH_DESC_LEN = 4'd4,
    PH_DESC_TXT = 4'd5,
    PH_ICON_LEN = 4'd6,
    PH_ICON_TXT = 4'd7,
    PH_DONE     = 4'd8,
    PH_ERROR    = 4'd9
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_SHORT       = 3'd1,
    ST_BAD_VERSION = 3'd2,
    ST_TRUNCATED   = 3'd3,
    ST_TOO_LONG    = 3'd4,
    ST_TRAILING    = 3'd5
  } status_e;

  typedef enum logic {
    KIND_TEXT    = 1'b0,
    KIND_VERDICT = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    FIELD_NAME = 2'd0,
    FIELD_DESC = 2'd1,
    FIELD_ICON = 2'd2
  } field_e;

  typedef struct packed {
    logic [7:0]  expected_version;
    logic [15:0] name_limit;
    logic [15:0] desc_limit;
    logic [15:0] icon_limit;
  } cfg_t;

  typedef struct packed {
    logic [15:0]        flag_bits;
    logic [31:0]        waypoint_id;
    logic signed [31:0] latitude;
    logic signed [31:0] longitude;
    logic [31:0]        expire_time;
    logic [31:0]        lock_holder;
  } hdr_t;

  // one classified byte: a string byte, a verdict, or both
  typedef struct packed {
    logic       has_str;
    field_e     text_field;
    logic [7:0] text_byte;
    logic       has_verdict;
    status_e    status;
    hdr_t       hdr;
  } entry_t;

  typedef struct packed {
    kind_e      kind;
    field_e     text_field;
    logic [7:0] text_byte;
    hdr_t       hdr;
    status_e    status;
    logic       run_last;
  } result_t;

endpackage

`default_nettype wire

/* rtl/wrp_front.sv */
// front end: parses record bytes, keeps record state, classifies each byte
// into a queue entry; depends on wrp_pkg
`default_nettype none

module wrp_front import wrp_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire cfg_t       cfg_i,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       final_byte_i,
  output logic            push_valid_o,
  input  wire logic       push_ready_i,
  output entry_t          push_data_o
);

  phase_e             phase_q, phase_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [15:0]        len_q, len_d;
  logic [SEEN_W-1:0]  seen_q, seen_d;
  status_e            err_q, err_d;
  logic [HDR_W-1:0]   hdr_q;
  logic               hdr_shift;
  logic               in_fire;

  // per-phase selections for the string phases
  field_e             sel;
  logic [15:0]        limit;
  phase_e             after_len, skip_len, after_txt;
  logic [15:0]        full_len;
  status_e            verdict;
  entry_t             ent;

  assign in_ready_o = push_ready_i;
  assign in_fire    = in_valid_i && push_ready_i;

  always_comb begin
    sel       = FIELD_NAME;
    limit     = cfg_i.name_limit;
    after_len = PH_NAME_TXT;
    skip_len  = PH_DESC_LEN;
    after_txt = PH_DESC_LEN;
    case (phase_q)
      PH_DESC_LEN, PH_DESC_TXT: begin
        sel       = FIELD_DESC;
        limit     = cfg_i.desc_limit;
        after_len = PH_DESC_TXT;
        skip_len  = PH_ICON_LEN;
        after_txt = PH_ICON_LEN;
      end
      PH_ICON_LEN, PH_ICON_TXT: begin
        sel       = FIELD_ICON;
        limit     = cfg_i.icon_limit;
        after_len = PH_ICON_TXT;
        skip_len  = PH_DONE;
        after_txt = PH_DONE;
      end
      default: ;
    endcase
  end

  always_comb begin
    phase_d   = phase_q;
    idx_d     = idx_q;
    len_d     = len_q;
    seen_d    = seen_q;
    err_d     = err_q;
    hdr_shift = 1'b0;
    full_len  = {data_byte_i, len_q[7:0]};
    verdict   = ST_OK;
    ent       = '0;
    if (in_fire) begin
      if (seen_q < SEEN_W'(MIN_RECORD_BYTES)) begin
        seen_d = seen_q + SEEN_W'(1);
      end
      case (phase_q)
        PH_VERSION: begin
          if (data_byte_i != cfg_i.expected_version) begin
            err_d   = ST_BAD_VERSION;
            phase_d = PH_ERROR;
          end else begin
            phase_d = PH_HEADER;
            idx_d   = '0;
          end
        end
        PH_HEADER: begin
          hdr_shift = 1'b1;
          if (idx_q == IDX_W'(HEADER_BYTES - 1)) begin
            idx_d   = '0;
            phase_d = PH_NAME_LEN;
          end else begin
            idx_d = idx_q + IDX_W'(1);
          end
        end
        PH_NAME_LEN, PH_DESC_LEN, PH_ICON_LEN: begin
          if (idx_q == '0) begin
            len_d = {8'h00, data_byte_i};
            idx_d = IDX_W'(1);
          end else begin
            len_d = full_len;
            idx_d = '0;
            // limit check comes before any remaining-length check
            if (full_len > limit) begin
              err_d   = ST_TOO_LONG;
              phase_d = PH_ERROR;
            end else if (full_len == '0) begin
              phase_d = skip_len;
            end else begin
              phase_d = after_len;
            end
          end
        end
        PH_NAME_TXT, PH_DESC_TXT, PH_ICON_TXT: begin
          ent.has_str    = 1'b1;
          ent.text_field = sel;
          ent.text_byte  = data_byte_i;
          len_d          = len_q - 16'd1;
          if (len_q == 16'd1) begin
            phase_d = after_txt;
          end
        end
        PH_DONE: begin
          err_d   = ST_TRAILING;
          phase_d = PH_ERROR;
        end
        default: ;
      endcase

      if (final_byte_i) begin
        if (seen_d < SEEN_W'(MIN_RECORD_BYTES)) begin
          verdict = ST_SHORT;
        end else if (err_d != ST_OK) begin
          verdict = err_d;
        end else if (phase_d != PH_DONE) begin
          verdict = ST_TRUNCATED;
        end else begin
          verdict = ST_OK;
        end
        ent.has_verdict = 1'b1;
        ent.status      = verdict;
        if (verdict == ST_OK) begin
          // byte k of the header sits at bits 8k+7:8k
          ent.hdr.flag_bits   = hdr_q[15:0];
          ent.hdr.waypoint_id = hdr_q[47:16];
          ent.hdr.latitude    = hdr_q[79:48];
          ent.hdr.longitude   = hdr_q[111:80];
          ent.hdr.expire_time = hdr_q[143:112];
          ent.hdr.lock_holder = hdr_q[175:144];
        end
        phase_d = PH_VERSION;
        idx_d   = '0;
        len_d   = '0;
        seen_d  = '0;
        err_d   = ST_OK;
      end
    end
  end

  assign push_valid_o = ent.has_str || ent.has_verdict;
  assign push_data_o  = ent;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_VERSION;
      idx_q   <= '0;
      len_q   <= '0;
      seen_q  <= '0;
      err_q   <= ST_OK;
    end else begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      len_q   <= len_d;
      seen_q  <= seen_d;
      err_q   <= err_d;
    end
  end

  // header bytes shift in from the top, so byte 0 lands in the low byte
  always_ff @(posedge clk_i) begin
    if (hdr_shift) begin
      hdr_q <= {data_byte_i, hdr_q[HDR_W-1:8]};
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && phase_q == PH_ERROR) |-> !ent.has_str)
    else $error("string byte emitted after a parse error");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DONE) |-> (err_q == ST_OK && seen_q == SEEN_W'(MIN_RECORD_BYTES)))
    else $error("complete record with error or short count");

endmodule

`default_nettype wire

/* rtl/wrp_queue.sv */
// short fifo between parser front end and result back end
// depends on wrp_pkg for the entry type
`default_nettype none

module wrp_queue import wrp_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_valid_i,
  output logic        push_ready_o,
  input  wire entry_t push_data_i,
  output logic        pop_valid_o,
  input  wire logic   pop_ready_i,
  output entry_t      pop_data_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  entry_t            mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              push_fire, pop_fire;

  assign push_ready_o = (count_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push_fire    = push_valid_i && push_ready_o;
  assign pop_fire     = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_fire) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_fire) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push_fire && !pop_fire) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop_fire && !push_fire) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_fire) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q <= CNT_W'(DEPTH)) &&
    ((count_q == '0 || count_q == CNT_W'(DEPTH)) == (wr_ptr_q == rd_ptr_q)))
    else $error("queue pointers and fill count disagree");

endmodule

`default_nettype wire

/* rtl/wrp_back.sv */
// back end: expands each queue entry into one or two results and holds
// them in the output register; depends on wrp_pkg
`default_nettype none

module wrp_back import wrp_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   pop_valid_i,
  output logic        pop_ready_o,
  input  wire entry_t pop_data_i,
  output logic        out_valid_o,
  input  wire logic   out_ready_i,
  output result_t     out_res_o
);

  logic    out_valid_q, out_valid_d;
  logic    str_done_q, str_done_d;
  result_t res_q, res_d;
  logic    load;

  // output slot is free when empty or being taken this cycle
  assign load = pop_valid_i && (!out_valid_q || out_ready_i);

  always_comb begin
    res_d       = res_q;
    str_done_d  = str_done_q;
    pop_ready_o = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    if (load) begin
      out_valid_d = 1'b1;
      res_d       = '0;
      if (pop_data_i.has_str && !str_done_q) begin
        res_d.kind       = KIND_TEXT;
        res_d.text_field = pop_data_i.text_field;
        res_d.text_byte  = pop_data_i.text_byte;
        res_d.run_last   = !pop_data_i.has_verdict;
        if (pop_data_i.has_verdict) begin
          str_done_d = 1'b1;
        end else begin
          pop_ready_o = 1'b1;
        end
      end else begin
        res_d.kind     = KIND_VERDICT;
        res_d.hdr      = pop_data_i.hdr;
        res_d.status   = pop_data_i.status;
        res_d.run_last = 1'b1;
        pop_ready_o    = 1'b1;
        str_done_d     = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      str_done_q  <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      str_done_q  <= str_done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = res_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_ready_i && res_q.kind == KIND_TEXT && !res_q.run_last)
    |=> (out_valid_q && res_q.kind == KIND_VERDICT))
    else $error("string byte of a final input not followed by its verdict");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.kind == KIND_VERDICT && res_q.status != ST_OK)
    |-> (res_q.hdr == '0))
    else $error("failed verdict carries header fields");

endmodule

`default_nettype wire

/* rtl/waypoint_record_parser.sv */
// top level of the waypoint record parser: configuration registers,
// front end, entry queue and back end; depends on wrp_pkg, wrp_front, wrp_queue, wrp_back
//
//   channel   direction  handshake                  payload
//   input     in         in_valid_i / in_ready_o    data_byte_i, final_byte_i
//   result    out        out_valid_o / out_ready_i  kind_o .. run_last_o
//   config    in         cfg_we_i (no wait)         cfg_index_i, cfg_data_i
//
// one byte is taken per cycle while the queue has room; its first result passes
// through the queue and then the output register before it reaches the outputs.
// a final byte that also carries a string byte yields two results, one after the other,
// so the result side runs at one result per cycle while out_ready_i is high.
// reset returns the parser to the version byte and the registers to their defaults.
// a stalled result side fills QUEUE_DEPTH entries plus the output register, then
// in_ready_o drops.
`default_nettype none

module waypoint_record_parser import wrp_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [7:0]           data_byte_i,
  input  wire logic                 final_byte_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic                      kind_o,
  output logic [1:0]                text_field_o,
  output logic [7:0]                text_byte_o,
  output logic [15:0]               flag_bits_o,
  output logic [31:0]               waypoint_id_o,
  output logic signed [31:0]        latitude_o,
  output logic signed [31:0]        longitude_o,
  output logic [31:0]               expire_time_o,
  output logic [31:0]               lock_holder_o,
  output logic [2:0]                status_o,
  output logic                      run_last_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i
);

  cfg_t    cfg_q;
  logic    push_valid, push_ready;
  entry_t  push_data;
  logic    pop_valid, pop_ready;
  entry_t  pop_data;
  result_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.expected_version <= RST_EXPECTED_VERSION;
      cfg_q.name_limit       <= RST_NAME_LIMIT;
      cfg_q.desc_limit       <= RST_DESC_LIMIT;
      cfg_q.icon_limit       <= RST_ICON_LIMIT;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_EXPECTED_VERSION: cfg_q.expected_version <= cfg_data_i[7:0];
        CFG_NAME_LIMIT:       cfg_q.name_limit       <= cfg_data_i;
        CFG_DESC_LIMIT:       cfg_q.desc_limit       <= cfg_data_i;
        CFG_ICON_LIMIT:       cfg_q.icon_limit       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  wrp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_byte_i  (data_byte_i),
    .final_byte_i (final_byte_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  wrp_queue #(
    .DEPTH (QUEUE_DEPTH_P)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  wrp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_res_o   (res)
  );

  assign kind_o        = res.kind;
  assign text_field_o  = res.text_field;
  assign text_byte_o   = res.text_byte;
  assign flag_bits_o   = res.hdr.flag_bits;
  assign waypoint_id_o = res.hdr.waypoint_id;
  assign latitude_o    = res.hdr.latitude;
  assign longitude_o   = res.hdr.longitude;
  assign expire_time_o = res.hdr.expire_time;
  assign lock_holder_o = res.hdr.lock_holder;
  assign status_o      = res.status;
  assign run_last_o    = res.run_last;

endmodule

`default_nettype wire

/* sim/waypoint_record_parser_test.sv */
`timescale 1ns / 100ps
// self-checking bench for waypoint_record_parser: a table of directed records, then
// random records under several register settings, scored by a local record decoder
// depends on wrp_pkg and the parser rtl
module waypoint_record_parser_test;
  import wrp_pkg::*;

  localparam int WATCHDOG_LIMIT = 500;
  localparam int SETTLE_CYCLES  = 20;
  localparam int MAX_TEXT       = 40;
  localparam int PHASE_BYTES    = 280;
  localparam int NUM_SETTINGS   = 5;
  localparam int NUM_ROWS       = 16;

  // header images, flags in the low bits: {lock, expiry, lon, lat, id, flags}
  localparam logic [175:0] HDR_ZERO  = '0;
  localparam logic [175:0] HDR_ONES  = '1;
  localparam logic [175:0] HDR_MIXED = {32'h8000_0000, 32'h0000_0001, 32'h8000_0000,
                                        32'h7FFF_FFFF, 32'h0123_4567, 16'h8001};
  localparam logic [175:0] HDR_SWAP  = {32'h0000_0001, 32'hFFFF_FFFE, 32'h7FFF_FFFF,
                                        32'h8000_0000, 32'hFEDC_BA98, 16'h0100};

  typedef struct packed {
    logic [7:0]   ver;
    logic [175:0] hdr;
    logic [15:0]  len0;
    logic [15:0]  len1;
    logic [15:0]  len2;
    logic [15:0]  cut;
    logic [3:0]   tail;
    logic         pinned;
    status_e      status;
  } record_row_t;

  logic                 clk_i;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [7:0]           data_byte_i = '0;
  logic                 final_byte_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic                 kind_o;
  logic [1:0]           text_field_o;
  logic [7:0]           text_byte_o;
  logic [15:0]          flag_bits_o;
  logic [31:0]          waypoint_id_o;
  logic signed [31:0]   latitude_o;
  logic signed [31:0]   longitude_o;
  logic [31:0]          expire_time_o;
  logic [31:0]          lock_holder_o;
  logic [2:0]           status_o;
  logic                 run_last_o;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0]     cfg_data_i = '0;

  waypoint_record_parser uut (.*);

  // decoder copy of the registers and the record state
  logic [7:0]  want_version;
  logic [15:0] text_limit [3];
  phase_e      dec_phase;
  logic [15:0] dec_index;
  logic [15:0] dec_length;
  int          dec_seen;
  logic [7:0]  hdr_bytes [HEADER_BYTES];
  status_e     dec_error;

  result_t     pending_results [$];
  logic [7:0]  record_bytes [$];

  int      errors = 0;
  int      bytes_sent = 0;
  int      records_sent = 0;
  int      results_seen = 0;
  int      verdicts_seen = 0;
  int      settings_used = 0;
  int      quiet_cycles = 0;
  bit      steady = 1'b0;
  bit      pin_on = 1'b0;
  status_e pin_status = ST_OK;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("waypoint_record_parser_test: errors");
      $finish;
    end
  end

  function automatic void clear_record();
    dec_phase  = PH_VERSION;
    dec_index  = '0;
    dec_length = '0;
    dec_seen   = 0;
    dec_error  = ST_OK;
    foreach (hdr_bytes[k]) hdr_bytes[k] = '0;
  endfunction

  function automatic void append_result(input result_t r);
    pending_results = {pending_results, r};
  endfunction

  function automatic void append_byte(input logic [7:0] b);
    record_bytes = {record_bytes, b};
  endfunction

  function automatic void abort_record(input status_e why);
    dec_error = why;
    dec_phase = PH_ERROR;
  endfunction

  // expected results for one accepted record byte
  function automatic void decode_byte(input logic [7:0] b, input logic fin);
    result_t r;
    int      made;
    made = 0;
    if (dec_seen < MIN_RECORD_BYTES) dec_seen++;
    case (dec_phase)
      PH_VERSION: begin
        if (b != want_version) abort_record(ST_BAD_VERSION);
        else begin
          dec_phase = PH_HEADER;
          dec_index = '0;
        end
      end
      PH_HEADER: begin
        hdr_bytes[dec_index] = b;
        dec_index++;
        if (dec_index >= HEADER_BYTES) begin
          dec_index = '0;
          dec_phase = PH_NAME_LEN;
        end
      end
      PH_NAME_LEN, PH_DESC_LEN, PH_ICON_LEN: begin
        if (dec_index == 0) begin
          dec_length = {8'h00, b};
          dec_index  = 16'd1;
        end else begin
          dec_length[15:8] = b;
          dec_index = '0;
          // limit check comes before any look at the bytes left
          if (dec_length > text_limit[(dec_phase - PH_NAME_LEN) / 2])
            abort_record(ST_TOO_LONG);
          else if (dec_length == 0) dec_phase = phase_e'(dec_phase + 2);
          else dec_phase = phase_e'(dec_phase + 1);
        end
      end
      PH_NAME_TXT, PH_DESC_TXT, PH_ICON_TXT: begin
        r = '0;
        r.kind       = KIND_TEXT;
        r.text_field = field_e'((dec_phase - PH_NAME_TXT) / 2);
        r.text_byte  = b;
        append_result(r);
        made++;
        dec_length--;
        if (dec_length == 0) dec_phase = phase_e'(dec_phase + 1);
      end
      PH_DONE: abort_record(ST_TRAILING);
      default: ;
    endcase

    if (fin) begin
      r = '0;
      r.kind = KIND_VERDICT;
      // short beats everything, then the first error in byte order
      if (dec_seen < MIN_RECORD_BYTES) r.status = ST_SHORT;
      else if (dec_error != ST_OK) r.status = dec_error;
      else if (dec_phase != PH_DONE) r.status = ST_TRUNCATED;
      else r.status = ST_OK;
      if (r.status == ST_OK) begin
        r.hdr.flag_bits = {hdr_bytes[1], hdr_bytes[0]};
        for (int k = 0; k < 4; k++) begin
          r.hdr.waypoint_id[8*k +: 8] = hdr_bytes[2 + k];
          r.hdr.latitude[8*k +: 8]    = hdr_bytes[6 + k];
          r.hdr.longitude[8*k +: 8]   = hdr_bytes[10 + k];
          r.hdr.expire_time[8*k +: 8] = hdr_bytes[14 + k];
          r.hdr.lock_holder[8*k +: 8] = hdr_bytes[18 + k];
        end
      end
      append_result(r);
      made++;
      clear_record();
    end

    if (made > 0) begin
      r = pending_results.pop_back();
      r.run_last = 1'b1;
      append_result(r);
    end
  endfunction

  function automatic void compare_field(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
    end
  endfunction

  // result side: random stalls, every accepted transaction scored in order
  initial begin : result_sink
    result_t want;
    int      stall;
    forever begin
      stall = steady ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      results_seen++;
      if (kind_o == KIND_VERDICT) verdicts_seen++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result with nothing pending, expected none actual kind %0d status %0d",
                 $time, kind_o, status_o);
      end else begin
        want = pending_results.pop_front();
        compare_field("kind", want.kind, kind_o);
        compare_field("text_field", want.text_field, text_field_o);
        compare_field("text_byte", want.text_byte, text_byte_o);
        compare_field("flag_bits", want.hdr.flag_bits, flag_bits_o);
        compare_field("waypoint_id", want.hdr.waypoint_id, waypoint_id_o);
        compare_field("latitude", want.hdr.latitude, latitude_o);
        compare_field("longitude", want.hdr.longitude, longitude_o);
        compare_field("expire_time", want.hdr.expire_time, expire_time_o);
        compare_field("lock_holder", want.hdr.lock_holder, lock_holder_o);
        compare_field("status", want.status, status_o);
        compare_field("run_last", want.run_last, run_last_o);
      end
    end
  end

  // called at a clock edge; returns at the edge where the transaction went through
  task automatic push_byte(input logic [7:0] b, input logic fin);
    int      gap;
    result_t typed;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    data_byte_i  <= b;
    final_byte_i <= fin;
    do @(posedge clk_i); while (!in_ready_o);
    bytes_sent++;
    decode_byte(b, fin);
    // table rows with a verdict known at a glance replace the decoder's verdict
    if (fin && pin_on) begin
      void'(pending_results.pop_back());
      typed = '0;
      typed.kind     = KIND_VERDICT;
      typed.status   = pin_status;
      typed.run_last = 1'b1;
      append_result(typed);
    end
  endtask

  task automatic release_input();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic hold_off();
    release_input();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e which, input logic [CFG_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= which;
    cfg_data_i  <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (which)
      CFG_EXPECTED_VERSION: want_version  = value[7:0];
      CFG_NAME_LIMIT:       text_limit[0] = value;
      CFG_DESC_LIMIT:       text_limit[1] = value;
      CFG_ICON_LIMIT:       text_limit[2] = value;
      default: ;
    endcase
  endtask

  // text beyond MAX_TEXT is never sent: such records end truncated or already failed
  function automatic void build_record(input logic [7:0] ver, input logic [175:0] hdr,
                                       input logic [15:0] len0, input logic [15:0] len1,
                                       input logic [15:0] len2, input int tail);
    logic [15:0] lens [3];
    lens = '{len0, len1, len2};
    record_bytes.delete();
    append_byte(ver);
    for (int k = 0; k < HEADER_BYTES; k++) append_byte(hdr[8*k +: 8]);
    for (int s = 0; s < 3; s++) begin
      append_byte(lens[s][7:0]);
      append_byte(lens[s][15:8]);
      for (int k = 0; k < lens[s] && k < MAX_TEXT; k++)
        append_byte(8'($urandom));
    end
    repeat (tail) append_byte(8'($urandom));
  endfunction

  // cut of zero sends the whole record; final byte rides on the last one sent
  task automatic send_record(input int cut);
    int count;
    count = (cut > 0 && cut < record_bytes.size()) ? cut : record_bytes.size();
    for (int k = 0; k < count; k++) push_byte(record_bytes[k], k == count - 1);
    records_sent++;
  endtask

  function automatic logic [15:0] text_length(input int s);
    logic [15:0] top;
    top = (text_limit[s] < MAX_TEXT) ? text_limit[s] : 16'(MAX_TEXT);
    if ($urandom_range(0, 4) == 0) return top;
    return 16'($urandom_range(0, (top < 6) ? top : 6));
  endfunction

  // mostly well-formed records with random content, the rest broken or noise
  task automatic random_record();
    logic [191:0] raw;
    logic [15:0]  lens [3];
    logic [7:0]   ver;
    int           mode;
    int           cut;
    int           tail;
    int           pick;
    raw  = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    ver  = want_version;
    cut  = 0;
    tail = 0;
    for (int s = 0; s < 3; s++) lens[s] = text_length(s);
    mode = $urandom_range(0, 19);
    case (mode)
      14: ver = want_version ^ 8'($urandom_range(1, 255));
      15: begin
        pick = $urandom_range(0, 2);
        if (text_limit[pick] != 16'hFFFF) lens[pick] = text_limit[pick] + 16'd1;
      end
      17: tail = $urandom_range(1, 3);
      18: lens[$urandom_range(0, 2)] = 16'($urandom);
      default: ;
    endcase
    if (mode == 19) begin
      record_bytes.delete();
      repeat ($urandom_range(1, 40)) append_byte(8'($urandom));
    end else begin
      build_record(ver, raw[175:0], lens[0], lens[1], lens[2], tail);
    end
    if (mode == 16) cut = $urandom_range(1, record_bytes.size() - 1);
    send_record(cut);
  endtask

  initial begin : stimulus
    record_row_t rows [NUM_ROWS];
    int          phase_start;

    want_version = RST_EXPECTED_VERSION;
    text_limit   = '{RST_NAME_LIMIT, RST_DESC_LIMIT, RST_ICON_LIMIT};
    clear_record();

    rows = '{
      '{8'h01, HDR_ZERO,  16'd0,  16'd0,   16'd0,  16'd1,  4'd0, 1'b1, ST_SHORT},
      '{8'h01, HDR_ONES,  16'd0,  16'd0,   16'd0,  16'd28, 4'd0, 1'b1, ST_SHORT},
      '{8'h01, HDR_ZERO,  16'd0,  16'd0,   16'd0,  16'd0,  4'd0, 1'b0, ST_OK},
      '{8'h01, HDR_ONES,  16'd0,  16'd0,   16'd0,  16'd0,  4'd0, 1'b0, ST_OK},
      '{8'h01, HDR_MIXED, 16'd1,  16'd2,   16'd1,  16'd0,  4'd0, 1'b0, ST_OK},
      '{8'h00, HDR_ONES,  16'd0,  16'd0,   16'd0,  16'd0,  4'd0, 1'b1, ST_BAD_VERSION},
      '{8'hFF, HDR_ZERO,  16'd3,  16'd0,   16'd0,  16'd0,  4'd0, 1'b1, ST_BAD_VERSION},
      '{8'h01, HDR_SWAP,  16'd33, 16'd0,   16'd0,  16'd0,  4'd0, 1'b1, ST_TOO_LONG},
      '{8'h01, HDR_ZERO,  16'd0,  16'd257, 16'd0,  16'd0,  4'd0, 1'b1, ST_TOO_LONG},
      '{8'h01, HDR_ONES,  16'd0,  16'd0,   16'd33, 16'd0,  4'd0, 1'b1, ST_TOO_LONG},
      '{8'h01, HDR_MIXED, 16'd32, 16'd3,   16'd32, 16'd0,  4'd0, 1'b0, ST_OK},
      '{8'h01, HDR_ZERO,  16'd10, 16'd0,   16'd0,  16'd30, 4'd0, 1'b1, ST_TRUNCATED},
      '{8'h01, HDR_ONES,  16'd1,  16'd1,   16'd1,  16'd0,  4'd2, 1'b1, ST_TRAILING},
      // too-long name inside a record that is also short
      '{8'h01, HDR_ZERO,  16'd40, 16'd0,   16'd0,  16'd26, 4'd0, 1'b1, ST_SHORT},
      '{8'h01, HDR_SWAP,  16'd0,  16'd0,   16'd0,  16'd0,  4'd1, 1'b1, ST_TRAILING},
      // last icon byte and verdict come from the same byte
      '{8'h01, HDR_ZERO,  16'd0,  16'd0,   16'd2,  16'd0,  4'd0, 1'b0, ST_OK}
    };

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int k = 0; k < NUM_ROWS; k++) begin
      steady     = (k % 3 == 0);
      pin_on     = rows[k].pinned;
      pin_status = rows[k].status;
      build_record(rows[k].ver, rows[k].hdr, rows[k].len0, rows[k].len1, rows[k].len2,
                   rows[k].tail);
      send_record(rows[k].cut);
    end
    pin_on = 1'b0;
    hold_off();

    for (int p = 0; p < NUM_SETTINGS; p++) begin
      case (p)
        0: begin
          write_reg(CFG_EXPECTED_VERSION, {8'($urandom), 8'h00});
          write_reg(CFG_NAME_LIMIT, 16'h0000);
          write_reg(CFG_DESC_LIMIT, 16'h0000);
          write_reg(CFG_ICON_LIMIT, 16'h0000);
        end
        1: begin
          write_reg(CFG_EXPECTED_VERSION, 16'h00FF);
          write_reg(CFG_NAME_LIMIT, 16'hFFFF);
          write_reg(CFG_DESC_LIMIT, 16'hFFFF);
          write_reg(CFG_ICON_LIMIT, 16'hFFFF);
        end
        2: begin
          write_reg(CFG_EXPECTED_VERSION, 16'($urandom));
          write_reg(CFG_NAME_LIMIT, 16'($urandom_range(0, 40)));
          write_reg(CFG_DESC_LIMIT, 16'($urandom_range(0, 40)));
          write_reg(CFG_ICON_LIMIT, 16'($urandom_range(0, 40)));
        end
        3: begin
          write_reg(CFG_EXPECTED_VERSION, 16'($urandom));
          write_reg(CFG_NAME_LIMIT, 16'($urandom_range(0, 300)));
          write_reg(CFG_DESC_LIMIT, 16'($urandom_range(0, 300)));
          write_reg(CFG_ICON_LIMIT, 16'($urandom_range(0, 300)));
        end
        default: begin
          write_reg(CFG_EXPECTED_VERSION, {8'($urandom), RST_EXPECTED_VERSION});
          write_reg(CFG_NAME_LIMIT, RST_NAME_LIMIT);
          write_reg(CFG_DESC_LIMIT, RST_DESC_LIMIT);
          write_reg(CFG_ICON_LIMIT, RST_ICON_LIMIT);
        end
      endcase
      settings_used++;
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) begin
        steady = ($urandom_range(0, 4) == 0);
        // now and then hold the input until the result side has caught up
        if ($urandom_range(0, 7) == 0) begin
          release_input();
          drain();
        end
        random_record();
      end
      hold_off();
    end

    $display("sent %0d records (%0d bytes) under reset values and %0d register settings",
             records_sent, bytes_sent, settings_used);
    $display("scored %0d results, %0d of them verdicts", results_seen, verdicts_seen);
    if (errors == 0) begin
      $display("waypoint_record_parser_test: clean");
    end else begin
      $display("waypoint_record_parser_test: errors");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/wrp_pkg.sv
rtl/wrp_front.sv
rtl/wrp_queue.sv
rtl/wrp_back.sv
rtl/waypoint_record_parser.sv
sim/waypoint_record_parser_test.sv
